@@ hw/rtl/ttet_pkg.sv @@
// types, codes and character constants for the tagged text event tokenizer
// no dependencies; used by tagged_text_event_tokenizer_unit
package ttet_pkg;

    // nesting limit: one container more than the limit may be open
    localparam int MAX_NESTING = 100;
    localparam int STACK_DEPTH = MAX_NESTING + 1;
    localparam int LVL_W       = $clog2(STACK_DEPTH + 1);
    localparam int STK_AW      = $clog2(STACK_DEPTH);

    // lexer modes
    typedef enum logic [2:0] {
        MODE_VALUE  = 3'd0,
        MODE_QUOTE  = 3'd1,
        MODE_STRING = 3'd2,
        MODE_ESCAPE = 3'd3,
        MODE_HEX1   = 3'd4,
        MODE_HEX2   = 3'd5,
        MODE_HEXBAD = 3'd6
    } t_mode;

    // bracket kinds held on the stack
    typedef enum logic [1:0] {
        BR_MAP = 2'd0,
        BR_SEQ = 2'd1,
        BR_SET = 2'd2
    } t_bracket;

    // event codes
    typedef enum logic [3:0] {
        EV_MAP_START    = 4'd0,
        EV_MAP_END      = 4'd1,
        EV_SEQ_START    = 4'd2,
        EV_SEQ_END      = 4'd3,
        EV_SET_START    = 4'd4,
        EV_SET_END      = 4'd5,
        EV_NULL         = 4'd6,
        EV_SCALAR_START = 4'd7,
        EV_SCALAR_BYTE  = 4'd8,
        EV_SCALAR_END   = 4'd9,
        EV_DONE         = 4'd10,
        EV_FAILED       = 4'd11
    } t_event;

    // error codes
    typedef enum logic [3:0] {
        ERR_NONE           = 4'd0,
        ERR_OPEN_QUOTE     = 4'd1,
        ERR_BAD_X_ESCAPE   = 4'd2,
        ERR_BAD_HEX        = 4'd3,
        ERR_UNKNOWN_ESCAPE = 4'd4,
        ERR_UNTERM_STRING  = 4'd5,
        ERR_MAX_DEPTH      = 4'd6,
        ERR_UNEXPECTED_END = 4'd7,
        ERR_UNTERM_CONT    = 4'd8,
        ERR_UNEXPECTED_TOK = 4'd9,
        ERR_TRAILING       = 4'd10
    } t_err;

    // scalar value types
    localparam logic [2:0] VT_NULL   = 3'd0;
    localparam logic [2:0] VT_NUMBER = 3'd1;
    localparam logic [2:0] VT_STRING = 3'd2;
    localparam logic [2:0] VT_BOOL   = 3'd3;
    localparam logic [2:0] VT_BINARY = 3'd4;

    // characters
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_RBRACK  = 8'h5D;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_Z       = 8'h5A;
    localparam logic [7:0] CH_P       = 8'h50;
    localparam logic [7:0] CH_N       = 8'h4E;
    localparam logic [7:0] CH_S       = 8'h53;
    localparam logic [7:0] CH_B       = 8'h42;
    localparam logic [7:0] CH_Y       = 8'h59;
    localparam logic [7:0] CH_X_LOWER = 8'h78;

    // request payloads
    typedef struct packed {
        logic       kind;
        logic [7:0] text_byte;
    } t_in_item;

    typedef struct packed {
        logic [3:0] event_code;
        logic [2:0] scalar_type;
        logic [7:0] data_byte;
        logic [3:0] error_code;
    } t_out_item;

    // hex digit decode: bit 4 set means not a hex digit
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] v;
        v = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = {1'b0, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = {1'b0, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = {1'b0, 4'(c - 8'h37)};
        end
        return v;
    endfunction

endpackage

@@ hw/rtl/tagged_text_event_tokenizer_unit.sv @@
// tagged text event tokenizer: one byte per cycle when not stalled, events streamed out
// an accepted request sits in the input register, and its event, if it makes one, is
//   written to the result register when it fires; one request per cycle unless the
//   result register stalls, set by the single-pass decode between the two registers
// the bracket stack is a memory with a registered read, prefetched one level below the top
// reset (i_rst_n low, synchronous) empties both registers and returns the lexer to
//   expecting a value; the stack memory is not cleared, only pushed entries are read
// depends on ttet_pkg
module tagged_text_event_tokenizer_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  ttet_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ttet_pkg::t_out_item o_out_item
);

    // input register
    logic               r_in_vld;
    ttet_pkg::t_in_item r_in;

    // lexer state
    ttet_pkg::t_mode             r_mode, n_mode;
    logic [2:0]                  r_ptype, n_ptype;
    logic [3:0]                  r_nib, n_nib;
    logic [ttet_pkg::LVL_W-1:0]  r_level, n_level;
    logic                        r_topc, n_topc;
    ttet_pkg::t_err              r_err, n_err;
    logic [1:0]                  r_top, n_top;

    // bracket stack memory and prefetched entry below the top
    logic [1:0]                  r_stack [ttet_pkg::STACK_DEPTH];
    logic [1:0]                  r_below;
    logic [ttet_pkg::STK_AW-1:0] rd_addr;
    logic [ttet_pkg::LVL_W-1:0]  lvl_next;

    // result register
    logic                r_out_vld;
    ttet_pkg::t_out_item r_out;

    // decode results
    logic                fire;
    logic                emit;
    logic                push;
    logic [1:0]          push_kind;
    ttet_pkg::t_out_item ev;
    ttet_pkg::t_err      end_err;
    logic [7:0]          c;
    logic [7:0]          closer;
    logic [4:0]          hv;
    logic                is_space;

    // handshake
    assign fire       = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || fire;
    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_item;
        end
    end

    // character helpers
    assign c  = r_in.text_byte;
    assign hv = ttet_pkg::hex_digit(c);

    always_comb begin
        case (c)
            ttet_pkg::CH_SPACE, ttet_pkg::CH_TAB,
            ttet_pkg::CH_LF, ttet_pkg::CH_CR: is_space = 1'b1;
            default:                          is_space = 1'b0;
        endcase
    end

    always_comb begin
        case (r_top)
            ttet_pkg::BR_SEQ: closer = ttet_pkg::CH_RBRACK;
            ttet_pkg::BR_SET: closer = ttet_pkg::CH_RPAREN;
            default:          closer = ttet_pkg::CH_RBRACE;
        endcase
    end

    // error reported at the end request
    always_comb begin
        end_err = r_err;
        if (r_err == ttet_pkg::ERR_NONE) begin
            case (r_mode)
                ttet_pkg::MODE_VALUE: begin
                    if (r_level != '0) begin
                        end_err = ttet_pkg::ERR_UNTERM_CONT;
                    end else if (!r_topc) begin
                        end_err = ttet_pkg::ERR_UNEXPECTED_END;
                    end
                end
                ttet_pkg::MODE_QUOTE:  end_err = ttet_pkg::ERR_OPEN_QUOTE;
                ttet_pkg::MODE_STRING,
                ttet_pkg::MODE_ESCAPE: end_err = ttet_pkg::ERR_UNTERM_STRING;
                default:               end_err = ttet_pkg::ERR_BAD_X_ESCAPE;
            endcase
        end
    end

    // single-pass decode of one request
    always_comb begin
        n_mode    = r_mode;
        n_ptype   = r_ptype;
        n_nib     = r_nib;
        n_level   = r_level;
        n_topc    = r_topc;
        n_err     = r_err;
        n_top     = r_top;
        emit      = 1'b0;
        push      = 1'b0;
        push_kind = ttet_pkg::BR_MAP;
        ev        = '0;

        if (r_in.kind) begin
            // end of text: report and go back to the reset state
            emit    = 1'b1;
            ev.event_code = (end_err != ttet_pkg::ERR_NONE) ? ttet_pkg::EV_FAILED
                                                             : ttet_pkg::EV_DONE;
            ev.error_code = end_err;
            n_mode  = ttet_pkg::MODE_VALUE;
            n_ptype = ttet_pkg::VT_NULL;
            n_nib   = '0;
            n_level = '0;
            n_topc  = 1'b0;
            n_err   = ttet_pkg::ERR_NONE;
        end else if (r_err == ttet_pkg::ERR_NONE) begin
            case (r_mode)
                ttet_pkg::MODE_VALUE: begin
                    if (is_space) begin
                        emit = 1'b0;
                    end else if (r_topc) begin
                        n_err = ttet_pkg::ERR_TRAILING;
                    end else if (r_level != '0 && c == closer) begin
                        // close the innermost container
                        emit          = 1'b1;
                        n_level       = r_level - ttet_pkg::LVL_W'(1);
                        n_top         = r_below;
                        ev.event_code = {1'b0, r_top, 1'b1};
                        if (n_level == '0) begin
                            n_topc = 1'b1;
                        end
                    end else if (r_level > ttet_pkg::LVL_W'(ttet_pkg::MAX_NESTING)) begin
                        n_err = ttet_pkg::ERR_MAX_DEPTH;
                    end else if (c == ttet_pkg::CH_LBRACE || c == ttet_pkg::CH_LBRACK
                                 || c == ttet_pkg::CH_LPAREN) begin
                        // open a container
                        push_kind = (c == ttet_pkg::CH_LBRACK) ? ttet_pkg::BR_SEQ :
                                    (c == ttet_pkg::CH_LPAREN) ? ttet_pkg::BR_SET :
                                                                 ttet_pkg::BR_MAP;
                        push          = 1'b1;
                        emit          = 1'b1;
                        n_level       = r_level + ttet_pkg::LVL_W'(1);
                        n_top         = push_kind;
                        ev.event_code = {1'b0, push_kind, 1'b0};
                    end else if (c == ttet_pkg::CH_Z) begin
                        emit          = 1'b1;
                        ev.event_code = ttet_pkg::EV_NULL;
                        if (r_level == '0) begin
                            n_topc = 1'b1;
                        end
                    end else begin
                        // type letter or bad token
                        emit = 1'b1;
                        case (c)
                            ttet_pkg::CH_P: n_ptype = ttet_pkg::VT_NULL;
                            ttet_pkg::CH_N: n_ptype = ttet_pkg::VT_NUMBER;
                            ttet_pkg::CH_S: n_ptype = ttet_pkg::VT_STRING;
                            ttet_pkg::CH_B: n_ptype = ttet_pkg::VT_BOOL;
                            ttet_pkg::CH_Y: n_ptype = ttet_pkg::VT_BINARY;
                            default: begin
                                emit  = 1'b0;
                                n_err = ttet_pkg::ERR_UNEXPECTED_TOK;
                            end
                        endcase
                        if (emit) begin
                            n_mode         = ttet_pkg::MODE_QUOTE;
                            ev.event_code  = ttet_pkg::EV_SCALAR_START;
                            ev.scalar_type = n_ptype;
                        end
                    end
                end
                ttet_pkg::MODE_QUOTE: begin
                    if (c != ttet_pkg::CH_QUOTE) begin
                        n_err = ttet_pkg::ERR_OPEN_QUOTE;
                    end else begin
                        n_mode = ttet_pkg::MODE_STRING;
                    end
                end
                ttet_pkg::MODE_STRING: begin
                    ev.scalar_type = r_ptype;
                    if (c == ttet_pkg::CH_QUOTE) begin
                        emit          = 1'b1;
                        n_mode        = ttet_pkg::MODE_VALUE;
                        ev.event_code = ttet_pkg::EV_SCALAR_END;
                        if (r_level == '0) begin
                            n_topc = 1'b1;
                        end
                    end else if (c == ttet_pkg::CH_BSLASH) begin
                        n_mode = ttet_pkg::MODE_ESCAPE;
                    end else begin
                        emit          = 1'b1;
                        ev.event_code = ttet_pkg::EV_SCALAR_BYTE;
                        ev.data_byte  = c;
                    end
                end
                ttet_pkg::MODE_ESCAPE: begin
                    if (c == ttet_pkg::CH_BSLASH || c == ttet_pkg::CH_QUOTE) begin
                        emit           = 1'b1;
                        n_mode         = ttet_pkg::MODE_STRING;
                        ev.event_code  = ttet_pkg::EV_SCALAR_BYTE;
                        ev.scalar_type = r_ptype;
                        ev.data_byte   = c;
                    end else if (c == ttet_pkg::CH_X_LOWER) begin
                        n_mode = ttet_pkg::MODE_HEX1;
                    end else begin
                        n_err = ttet_pkg::ERR_UNKNOWN_ESCAPE;
                    end
                end
                ttet_pkg::MODE_HEX1: begin
                    if (hv[4]) begin
                        n_mode = ttet_pkg::MODE_HEXBAD;
                    end else begin
                        n_nib  = hv[3:0];
                        n_mode = ttet_pkg::MODE_HEX2;
                    end
                end
                ttet_pkg::MODE_HEX2: begin
                    if (hv[4]) begin
                        n_err = ttet_pkg::ERR_BAD_HEX;
                    end else begin
                        emit           = 1'b1;
                        n_mode         = ttet_pkg::MODE_STRING;
                        ev.event_code  = ttet_pkg::EV_SCALAR_BYTE;
                        ev.scalar_type = r_ptype;
                        ev.data_byte   = {r_nib, hv[3:0]};
                    end
                end
                default: begin
                    n_err = ttet_pkg::ERR_BAD_HEX;
                end
            endcase
        end
    end

    // lexer state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= ttet_pkg::MODE_VALUE;
            r_ptype <= ttet_pkg::VT_NULL;
            r_nib   <= '0;
            r_level <= '0;
            r_topc  <= 1'b0;
            r_err   <= ttet_pkg::ERR_NONE;
        end else if (fire) begin
            r_mode  <= n_mode;
            r_ptype <= n_ptype;
            r_nib   <= n_nib;
            r_level <= n_level;
            r_topc  <= n_topc;
            r_err   <= n_err;
        end
    end

    // top of stack copy
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_top <= n_top;
        end
    end

    // prefetch address: the entry just below the next top
    assign lvl_next = fire ? n_level : r_level;
    assign rd_addr  = (lvl_next < ttet_pkg::LVL_W'(2)) ? '0
                    : ttet_pkg::STK_AW'(lvl_next - ttet_pkg::LVL_W'(2));

    // stack memory: push writes at the current level, read is registered
    always_ff @(posedge i_clk) begin
        if (fire && push) begin
            r_stack[r_level[ttet_pkg::STK_AW-1:0]] <= push_kind;
        end
        r_below <= r_stack[rd_addr];
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (fire && emit) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
        if (fire && emit) begin
            r_out <= ev;
        end
    end

    // depth never exceeds the stack size
    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= ttet_pkg::LVL_W'(ttet_pkg::STACK_DEPTH))
        else $error("nesting level beyond stack depth");

    // end request always produces a report
    a_end_reports: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_in.kind |-> emit)
        else $error("end request without report");

    // end request returns the lexer to its idle state
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_in.kind |=> r_level == '0 && r_err == ttet_pkg::ERR_NONE
                              && r_mode == ttet_pkg::MODE_VALUE && !r_topc)
        else $error("state not cleared after end request");

    // no events once an error is latched
    a_quiet_after_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && !r_in.kind && r_err != ttet_pkg::ERR_NONE |-> !emit)
        else $error("event after latched error");

    // an error, once latched, stays until the end request
    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && !r_in.kind && r_err != ttet_pkg::ERR_NONE |=> $stable(r_err))
        else $error("latched error changed before end request");

endmodule
